// ===== hw/rtl/pvm_pkg.sv =====
// pvm_pkg: shared constants, command codes and controller/datapath interface types
// for the pcm voice mixer; no dependencies
package pvm_pkg;

	localparam int VOICES      = 8;
	localparam int VIDX_W      = 3;
	localparam int STORE_BYTES = 65536;
	localparam int ADDR_W      = 16;
	localparam int STEP_W      = 32;
	localparam int DIV_STEPS   = 32;
	localparam int CNT_W       = 6;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] CMD_STOP  = 2'd3;

	localparam logic CFG_OUTPUT_RATE     = 1'b0;
	localparam logic CFG_ACTIVE_CHANNELS = 1'b1;

	localparam logic [15:0] OUTPUT_RATE_RESET = 16'd8000;
	localparam logic [3:0]  ACTIVE_CH_RESET   = 4'd8;

	// controller -> datapath commands
	typedef struct packed {
		logic              latch;      // capture the accepted item
		logic              store_wr;   // write the sample byte
		logic              div_init;   // load the step divider
		logic              div_step;   // one restoring division step
		logic              start_wr;   // commit a voice start
		logic              stop_wr;    // clear a voice
		logic              acc_clr;    // clear the mix sum
		logic              rd_issue;   // read the store for the current voice
		logic              voice_upd;  // accumulate and advance the current voice
		logic [VIDX_W-1:0] voice;      // voice under work
		logic              finish;     // present the result
	} pvm_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic [1:0] command;
		logic       start_ok;
		logic [3:0] mix_count;
	} pvm_sts_t;

endpackage

// ===== hw/rtl/pvm_ctrl.sv =====
// pvm_ctrl: sequencer for the pcm voice mixer
// depends on pvm_pkg
module pvm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pvm_pkg::pvm_sts_t sts,
	output pvm_pkg::pvm_cmd_t cmd
);
	import pvm_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_ACC    = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VIDX_W:0]   voice_q;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.voice   = voice_q[VIDX_W-1:0];
		cmd.latch   = (state_q == ST_IDLE) && start;
		unique case (state_q)
			ST_DECODE: begin
				unique case (sts.command)
					CMD_LOAD:  cmd.store_wr = 1'b1;
					CMD_START: cmd.div_init = sts.start_ok;
					CMD_STOP:  cmd.stop_wr  = 1'b1;
					CMD_TICK:  cmd.acc_clr  = 1'b1;
					default:   cmd.store_wr = 1'b0;
				endcase
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS))
					cmd.start_wr = 1'b1;
				else
					cmd.div_step = 1'b1;
			end
			ST_READ: cmd.rd_issue  = 1'b1;
			ST_ACC:  cmd.voice_upd = 1'b1;
			ST_DONE: cmd.finish    = 1'b1;
			default: cmd.finish    = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			voice_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (start) state_q <= ST_DECODE;
				ST_DECODE: begin
					cnt_q   <= '0;
					voice_q <= '0;
					priority if (sts.command == CMD_START && sts.start_ok)
						state_q <= ST_DIV;
					else if (sts.command == CMD_TICK && sts.mix_count != 4'd0)
						state_q <= ST_READ;
					else
						state_q <= ST_DONE;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS))
						state_q <= ST_DONE;
					cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_READ: state_q <= ST_ACC;
				ST_ACC: begin
					voice_q <= voice_q + (VIDX_W+1)'(1);
					if ({1'b0, voice_q} + 5'd1 >= {1'b0, sts.mix_count})
						state_q <= ST_DONE;
					else
						state_q <= ST_READ;
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/pvm_datapath.sv =====
// pvm_datapath: sample store, voice registers, step divider and mix accumulator
// depends on pvm_pkg
module pvm_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [1:0]         command,
	input  logic [2:0]         channel,
	input  logic [15:0]        address,
	input  logic [7:0]         sample_byte,
	input  logic [15:0]        length,
	input  logic [15:0]        voice_rate,
	input  logic [7:0]         volume,
	input  logic signed [15:0] music_sample,
	input  logic               music_valid,
	input  pvm_pkg::pvm_cmd_t  cmd,
	output pvm_pkg::pvm_sts_t  sts,
	output logic signed [15:0] mix_sample,
	output logic               sample_valid,
	output logic [7:0]         active_mask,
	output logic               error,
	output logic               done
);
	import pvm_pkg::*;

	logic [15:0] output_rate_q;
	logic [3:0]  active_ch_q;

	logic [1:0]  command_q;
	logic [2:0]  channel_q;
	logic [15:0] address_q;
	logic [7:0]  byte_q;
	logic [15:0] length_q;
	logic [7:0]  volume_q;
	logic signed [15:0] music_q;
	logic        mvalid_q;
	logic [15:0] rate_q;

	logic [7:0]  store_mem [STORE_BYTES];
	logic [7:0]  rd_q;

	logic [VOICES-1:0] active_q;
	logic [15:0] pos_q  [VOICES];
	logic [15:0] end_q  [VOICES];
	logic [31:0] step_q [VOICES];
	logic [15:0] frac_q [VOICES];
	logic [6:0]  gain_q [VOICES];

	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [31:0] dvd_q;
	logic signed [23:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_rate_q <= OUTPUT_RATE_RESET;
			active_ch_q   <= ACTIVE_CH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OUTPUT_RATE:     output_rate_q <= cfg_data;
				CFG_ACTIVE_CHANNELS: active_ch_q   <= cfg_data[3:0];
				default:             active_ch_q   <= active_ch_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			command_q <= command;
			channel_q <= channel;
			address_q <= address;
			byte_q    <= sample_byte;
			length_q  <= length;
			volume_q  <= volume;
			music_q   <= music_sample;
			mvalid_q  <= music_valid;
			rate_q    <= voice_rate;
		end
	end

	assign sts.command   = command_q;
	assign sts.start_ok  = (volume_q[7] == 1'b0);
	assign sts.mix_count = (active_ch_q > 4'(VOICES)) ? 4'(VOICES) : active_ch_q;

	always_ff @(posedge clk) begin
		if (cmd.store_wr)
			store_mem[address_q] <= byte_q;
		if (cmd.rd_issue)
			rd_q <= store_mem[pos_q[cmd.voice]];
	end

	// restoring division of rate<<16 by output_rate, one quotient bit a cycle
	logic [15:0] divisor;
	logic [16:0] rem_sh;
	logic [17:0] rem_sub;
	assign divisor = (output_rate_q == 16'd0) ? 16'd1 : output_rate_q;
	assign rem_sh  = {rem_q[15:0], dvd_q[31]};
	assign rem_sub = {1'b0, rem_sh} - {2'b00, divisor};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dvd_q <= {rate_q, 16'd0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (!rem_sub[17]) begin
				rem_q <= rem_sub[16:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// voice update for the current voice
	logic [VIDX_W-1:0] vi;
	logic signed [16:0] prod;
	logic signed [16:0] contrib;
	logic [32:0] acc;
	logic [17:0] nxt;
	logic [16:0] end_sum;
	logic [15:0] end_val;
	assign vi      = cmd.voice;
	assign prod    = 17'(($signed({1'b0, rd_q}) - 10'sd127) * $signed({1'b0, gain_q[vi]}));
	assign contrib = prod + (prod >>> 1);
	assign acc     = {1'b0, step_q[vi]} + {17'd0, frac_q[vi]};
	assign nxt     = {2'b00, pos_q[vi]} + {1'b0, acc[32:16]};
	assign end_sum = {1'b0, address_q} + {1'b0, length_q} - 17'd1;
	assign end_val = (length_q == 16'd0) ? address_q :
		(end_sum[16] ? 16'hffff : end_sum[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			for (int i = 0; i < VOICES; i++) begin
				pos_q[i]  <= '0;
				end_q[i]  <= '0;
				step_q[i] <= '0;
				frac_q[i] <= '0;
				gain_q[i] <= '0;
			end
		end else begin
			if (cmd.start_wr) begin
				pos_q[channel_q]    <= address_q;
				end_q[channel_q]    <= end_val;
				step_q[channel_q]   <= quo_q;
				frac_q[channel_q]   <= '0;
				gain_q[channel_q]   <= volume_q[6:0];
				active_q[channel_q] <= (length_q != 16'd0);
			end
			if (cmd.stop_wr)
				active_q[channel_q] <= 1'b0;
			if (cmd.voice_upd && active_q[vi]) begin
				frac_q[vi] <= acc[15:0];
				pos_q[vi]  <= nxt[15:0];
				if (nxt >= {2'b00, end_q[vi]})
					active_q[vi] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clr)
			sum_q <= '0;
		else if (cmd.voice_upd && active_q[vi])
			sum_q <= sum_q + 24'(contrib);
	end

	// result register
	logic signed [23:0] total;
	assign total = sum_q + (mvalid_q ? 24'(music_q) : 24'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			sample_valid <= (command_q == CMD_TICK);
			error        <= (command_q == CMD_START) && volume_q[7];
			active_mask  <= active_q;
			if (command_q != CMD_TICK)
				mix_sample <= '0;
			else if (total > 24'sd32767)
				mix_sample <= 16'sh7fff;
			else if (total < -24'sd32768)
				mix_sample <= 16'sh8000;
			else
				mix_sample <= total[15:0];
		end
	end

endmodule

// ===== hw/rtl/pcm_voice_mixer.sv =====
// pcm_voice_mixer: top level, joins the sequencer and the datapath
// depends on pvm_pkg, pvm_ctrl, pvm_datapath
//
// channel  | handshake        | payload
// command  | start / busy     | command channel address sample_byte length voice_rate volume
//          |                  | music_sample music_valid
// result   | done (strobe)    | mix_sample sample_valid active_mask error
// config   | cfg_we           | cfg_index cfg_data
//
// load, stop and a rejected start go from start through decode to done; an accepted start
// also runs the 32-step serial divider before done; a tick does one store read and
// one multiply-add per mixed voice, one voice after another.
// reset clears the voices and sets the config registers to their defaults; the store is not cleared.
// done is high for one cycle and the receiver cannot stall it.
module pcm_voice_mixer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [1:0]         command,
	input  logic [2:0]         channel,
	input  logic [15:0]        address,
	input  logic [7:0]         sample_byte,
	input  logic [15:0]        length,
	input  logic [15:0]        voice_rate,
	input  logic [7:0]         volume,
	input  logic signed [15:0] music_sample,
	input  logic               music_valid,
	output logic               done,
	output logic signed [15:0] mix_sample,
	output logic               sample_valid,
	output logic [7:0]         active_mask,
	output logic               error
);
	import pvm_pkg::*;

	pvm_cmd_t cmd;
	pvm_sts_t sts;

	pvm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	pvm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.channel      (channel),
		.address      (address),
		.sample_byte  (sample_byte),
		.length       (length),
		.voice_rate   (voice_rate),
		.volume       (volume),
		.music_sample (music_sample),
		.music_valid  (music_valid),
		.cmd          (cmd),
		.sts          (sts),
		.mix_sample   (mix_sample),
		.sample_valid (sample_valid),
		.active_mask  (active_mask),
		.error        (error),
		.done         (done)
	);

endmodule
